// ----- rtl/twp_pkg.sv -----
`timescale 1ns / 1ps
package twp_pkg;
  localparam int TW = 31;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_PRED  = 2'd2,
    ACT_EMIT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_PLAN_OVF = 2'd2,
    ST_WIN_OVF  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_READ,
    S_TEST,
    S_SVC0,
    S_SVC1,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [TW-1:0] a;
    logic [TW-1:0] b;
  } add_req_t;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[TW] ? TMAX : s[TW-1:0];
  endfunction
endpackage

// ----- rtl/twp_adder.sv -----
`timescale 1ns / 1ps
module twp_adder
  import twp_pkg::*;
(
  input  add_req_t      req,
  output logic [TW-1:0] sum
);
  assign sum = sat_add(req.a, req.b);
endmodule

// ----- rtl/time_window_propagation.sv -----
`timescale 1ns / 1ps
// Time window propagation for one route stop. Words on s_axis carry an action in tuser:
// begin latches travel/service and clears tables, load appends a customer window, a
// predecessor word shifts the departure window by travel time and tests it in order against the
// stored windows, emit streams the plan list on m_axis with tlast on the final entry.
// Begin and load complete in the idle state; a predecessor word adds travel time to the
// early and late departure, then per stored window reads, tests and, where the window is
// kept, adds service time twice, all sums going through one shared saturating adder; an
// emit gives one registered output word per plan entry (one for an empty list). The block
// takes no word while a predecessor or emit is in progress or an output word waits.
module time_window_propagation
  import twp_pkg::*;
#(
  parameter int MAX_WINDOWS = 8,
  parameter int MAX_PLANS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // travel_time, service_time, win_early, win_late, pred_early_departure,
  // pred_late_departure; 186 bits, pad to 192
  input  logic [191:0] s_axis_tdata,
  // action
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // early_arrival, late_arrival, early_departure, late_departure, wait_amount,
  // over_amount; 186 bits, pad to 192
  output logic [191:0] m_axis_tdata,
  output logic         m_axis_tlast,
  // status
  output logic [1:0]   m_axis_tuser
);
  localparam int WAW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int WCW = $clog2(MAX_WINDOWS + 1);
  localparam int PAW = (MAX_PLANS > 1) ? $clog2(MAX_PLANS) : 1;
  localparam int PCW = $clog2(MAX_PLANS + 1);

  logic [TW-1:0] window_open [MAX_WINDOWS];
  logic [TW-1:0] window_close [MAX_WINDOWS];
  logic [TW-1:0] plan_mem [MAX_PLANS][6];

  state_t state, state_next;
  logic [WCW-1:0] window_count;
  logic [PCW-1:0] plan_count, plan_count_next;
  logic [1:0] overflow_flags, overflow_flags_next;
  logic [TW-1:0] travel_latched, service_latched;
  logic [TW-1:0] ea, la, op, cl, a0, a1, d0, wt, ov;
  logic [TW-1:0] head_wait, head_over;
  logic [WCW-1:0] widx;
  logic [PCW-1:0] eidx;
  logic [0:0] shift_phase;
  logic feasible;
  logic do_append;
  logic [PAW-1:0] wr_addr;
  add_req_t add_req;
  logic [TW-1:0] add_sum;
  logic out_valid, out_last;
  logic [1:0] out_status;
  logic [TW-1:0] out_data [6];
  logic take;
  action_t act;

  twp_adder u_add (.req(add_req), .sum(add_sum));

  assign act = action_t'(s_axis_tuser);
  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign take = s_axis_tvalid && s_axis_tready;
  assign wr_addr = plan_count_next[PAW-1:0];

  always_comb begin
    add_req.a = ea;
    add_req.b = service_latched;
    case (state)
      S_SHIFT: begin
        add_req.a = shift_phase[0] ? la : ea;
        add_req.b = travel_latched;
      end
      S_SVC0: add_req.a = a0;
      S_SVC1: add_req.a = a1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    plan_count_next = plan_count;
    overflow_flags_next = overflow_flags;
    do_append = 1'b0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (act)
            ACT_BEGIN: begin
              plan_count_next = '0;
              overflow_flags_next = '0;
            end
            ACT_LOAD: if (window_count >= WCW'(MAX_WINDOWS)) overflow_flags_next[1] = 1'b1;
            ACT_PRED: state_next = S_SHIFT;
            ACT_EMIT: state_next = S_EMIT;
            default: ;
          endcase
        end
      end
      S_SHIFT: if (shift_phase[0]) state_next = S_READ;
      S_READ: state_next = (widx < window_count) ? S_TEST : S_IDLE;
      S_TEST: begin
        state_next = S_READ;
        if (la < op) begin
          if (feasible) state_next = S_IDLE;
          else if (plan_count == '0 || head_over != '0 || (op - la) < head_wait) begin
            plan_count_next = '0;
            state_next = S_SVC0;
          end
        end else if (ea > cl) begin
          if (!feasible && (plan_count == '0 || (head_wait == '0 && (ea - cl) < head_over))) begin
            plan_count_next = '0;
            state_next = S_SVC0;
          end
        end else begin
          if (!feasible) plan_count_next = '0;
          state_next = S_SVC0;
        end
      end
      S_SVC0: state_next = S_SVC1;
      S_SVC1: begin
        state_next = S_READ;
        if (plan_count >= PCW'(MAX_PLANS)) begin
          overflow_flags_next[0] = 1'b1;
        end else begin
          do_append = 1'b1;
          plan_count_next = plan_count + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid || m_axis_tready) begin
          if (plan_count == '0 || eidx + 1'b1 >= plan_count) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_SVC1) plan_count_next = do_append ? plan_count + 1'b1 : plan_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      window_count <= '0;
      plan_count <= '0;
      overflow_flags <= '0;
      travel_latched <= '0;
      service_latched <= '0;
      out_valid <= 1'b0;
      feasible <= 1'b0;
    end else begin
      state <= state_next;
      plan_count <= plan_count_next;
      overflow_flags <= overflow_flags_next;
      if (take && act == ACT_BEGIN) begin
        window_count <= '0;
        travel_latched <= s_axis_tdata[30:0];
        service_latched <= s_axis_tdata[61:31];
      end
      if (take && act == ACT_LOAD && window_count < WCW'(MAX_WINDOWS))
        window_count <= window_count + 1'b1;
      if (state == S_SHIFT && shift_phase[0])
        feasible <= (plan_count > PCW'(1)) ||
                    (plan_count == PCW'(1) && head_wait == '0 && head_over == '0);
      if (state == S_TEST && !(la < op) && !(ea > cl)) feasible <= 1'b1;
      if (state == S_EMIT && (!out_valid || m_axis_tready)) out_valid <= 1'b1;
      else if (out_valid && m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && act == ACT_LOAD && window_count < WCW'(MAX_WINDOWS)) begin
      window_open[window_count[WAW-1:0]] <= s_axis_tdata[92:62];
      window_close[window_count[WAW-1:0]] <= s_axis_tdata[123:93];
    end
    if (take) begin
      widx <= '0;
      eidx <= '0;
      shift_phase <= '0;
      ea <= s_axis_tdata[154:124];
      la <= s_axis_tdata[185:155];
    end
    if (state == S_SHIFT) begin
      shift_phase <= shift_phase + 1'b1;
      if (shift_phase[0]) la <= add_sum;
      else ea <= add_sum;
    end
    if (state == S_READ) begin
      op <= window_open[widx[WAW-1:0]];
      cl <= window_close[widx[WAW-1:0]];
      widx <= widx + 1'b1;
    end
    if (state == S_TEST) begin
      wt <= '0;
      ov <= '0;
      if (ea <= cl) begin
        if (la >= op) begin
          a0 <= (ea > op) ? ea : op;
          a1 <= (la < cl) ? la : cl;
        end else begin
          a0 <= op;
          a1 <= la;
          wt <= op - la;
        end
      end else begin
        a0 <= ea;
        a1 <= ea;
        ov <= ea - cl;
      end
    end
    if (state == S_SVC0) d0 <= add_sum;
    if (do_append) begin
      plan_mem[wr_addr - 1'b1][0] <= (wt != '0) ? a1 : a0;
      plan_mem[wr_addr - 1'b1][1] <= a1;
      plan_mem[wr_addr - 1'b1][2] <= d0;
      plan_mem[wr_addr - 1'b1][3] <= (wt != '0) ? d0 : add_sum;
      plan_mem[wr_addr - 1'b1][4] <= wt;
      plan_mem[wr_addr - 1'b1][5] <= ov;
      if (wr_addr == PAW'(1)) begin
        head_wait <= wt;
        head_over <= ov;
      end
    end
    if (state == S_IDLE && take && act == ACT_BEGIN) begin
      head_wait <= '0;
      head_over <= '0;
    end
    if (state == S_EMIT && (!out_valid || m_axis_tready)) begin
      if (plan_count == '0) begin
        for (int i = 0; i < 6; i++) out_data[i] <= '0;
        out_last <= 1'b1;
        out_status <= overflow_flags[1] ? ST_WIN_OVF : ST_EMPTY;
      end else begin
        for (int i = 0; i < 6; i++) out_data[i] <= plan_mem[eidx[PAW-1:0]][i];
        out_last <= (eidx + 1'b1 >= plan_count);
        out_status <= overflow_flags[1] ? ST_WIN_OVF :
                      (overflow_flags[0] ? ST_PLAN_OVF : ST_OK);
      end
      eidx <= eidx + 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast = out_last;
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {6'd0, out_data[5], out_data[4], out_data[3], out_data[2],
                         out_data[1], out_data[0]};
endmodule
